FILE: design/smx_pkg.sv
// Package for the stack machine execute block: opcodes, fault codes,
// default sizes, controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package smx_pkg;

    // default sizes (MEM_BYTES is taken as a power of two)
    localparam int STACK_DEPTH_DEF = 256;
    localparam int CALL_DEPTH_DEF  = 64;
    localparam int MEM_BYTES_DEF   = 65536;

    // opcodes
    localparam logic [4:0] OP_NOP  = 5'd0;
    localparam logic [4:0] OP_HALT = 5'd1;
    localparam logic [4:0] OP_TRAP = 5'd2;
    localparam logic [4:0] OP_LOAD = 5'd3;
    localparam logic [4:0] OP_STOR = 5'd4;
    localparam logic [4:0] OP_PUSH = 5'd5;
    localparam logic [4:0] OP_POP  = 5'd6;
    localparam logic [4:0] OP_DUP  = 5'd7;
    localparam logic [4:0] OP_ADD  = 5'd8;
    localparam logic [4:0] OP_SUB  = 5'd9;
    localparam logic [4:0] OP_MUL  = 5'd10;
    localparam logic [4:0] OP_DIV  = 5'd11;
    localparam logic [4:0] OP_MOD  = 5'd12;
    localparam logic [4:0] OP_AND  = 5'd13;
    localparam logic [4:0] OP_OR   = 5'd14;
    localparam logic [4:0] OP_XOR  = 5'd15;
    localparam logic [4:0] OP_NOT  = 5'd16;
    localparam logic [4:0] OP_LT   = 5'd17;
    localparam logic [4:0] OP_GT   = 5'd18;
    localparam logic [4:0] OP_EQ   = 5'd19;
    localparam logic [4:0] OP_JMP  = 5'd20;
    localparam logic [4:0] OP_JZ   = 5'd21;
    localparam logic [4:0] OP_JNZ  = 5'd22;
    localparam logic [4:0] OP_CALL = 5'd23;
    localparam logic [4:0] OP_RET  = 5'd24;

    // fault codes
    localparam logic [2:0] FLT_NONE  = 3'd0;
    localparam logic [2:0] FLT_UNDER = 3'd1;
    localparam logic [2:0] FLT_OVER  = 3'd2;
    localparam logic [2:0] FLT_DIV0  = 3'd3;
    localparam logic [2:0] FLT_CALL  = 3'd4;
    localparam logic [2:0] FLT_BADOP = 3'd5;

    // controller -> datapath strobes
    typedef struct packed {
        logic accept;     // latch request fields
        logic cap_a;      // capture stack top
        logic rd_b;       // address second entry
        logic check;      // capture second entry, work out fault
        logic div_init;   // load divider
        logic div_step;   // one divider iteration
        logic mem_lo;     // address low byte, capture high byte
        logic mem_wr_hi;  // write high byte of store
        logic mem_wr_lo;  // write low byte of store
        logic exec;       // commit state update
        logic fin;        // load result register
    } cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic skip;       // halted or faulted: no state change
        logic is_divmod;
        logic is_load;
        logic is_store;
        logic div_last;
        logic out_busy;
    } stat_t;

    // operands popped by each opcode
    function automatic logic [1:0] operands_needed(input logic [4:0] op);
        logic [1:0] n;
        begin
            n = 2'd0;
            case (op) inside
                OP_TRAP, OP_LOAD, OP_POP, OP_DUP, OP_NOT,
                OP_JMP, OP_JZ, OP_JNZ, OP_CALL: n = 2'd1;
                OP_STOR, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
                OP_AND, OP_OR, OP_XOR, OP_LT, OP_GT, OP_EQ: n = 2'd2;
                default: n = 2'd0;
            endcase
            return n;
        end
    endfunction

endpackage

FILE: design/smx_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module smx_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/smx_ctrl.sv
// Sequencer for the stack machine execute block: walks each instruction
// through operand fetch, check, divide / memory steps, commit and result.
// Depends on smx_pkg.
`timescale 1ns / 1ps

module smx_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  smx_pkg::stat_t stat,
    output smx_pkg::cmd_t  cmd
);
    import smx_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RDA  = 4'd1;
    localparam logic [3:0] S_RDB  = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_DIVI = 4'd4;
    localparam logic [3:0] S_DIVS = 4'd5;
    localparam logic [3:0] S_MEM1 = 4'd6;
    localparam logic [3:0] S_MEM2 = 4'd7;
    localparam logic [3:0] S_ST1  = 4'd8;
    localparam logic [3:0] S_ST2  = 4'd9;
    localparam logic [3:0] S_EXEC = 4'd10;
    localparam logic [3:0] S_TOP  = 4'd11;
    localparam logic [3:0] S_FIN  = 4'd12;

    logic [3:0] state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    // next state and strobes
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_RDA;
                end
            end
            S_RDA: state_next = S_RDB;
            S_RDB: begin
                cmd.cap_a  = 1'b1;
                cmd.rd_b   = 1'b1;
                state_next = S_CHK;
            end
            S_CHK: begin
                cmd.check = 1'b1;
                if (stat.skip) begin
                    state_next = S_TOP;
                end else if (stat.is_divmod) begin
                    state_next = S_DIVI;
                end else if (stat.is_load) begin
                    state_next = S_MEM1;
                end else if (stat.is_store) begin
                    state_next = S_ST1;
                end else begin
                    state_next = S_EXEC;
                end
            end
            S_DIVI: begin
                cmd.div_init = 1'b1;
                state_next   = S_DIVS;
            end
            S_DIVS: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = S_EXEC;
                end
            end
            S_MEM1: state_next = S_MEM2;
            S_MEM2: begin
                cmd.mem_lo = 1'b1;
                state_next = S_EXEC;
            end
            S_ST1: begin
                cmd.mem_wr_hi = 1'b1;
                state_next    = S_ST2;
            end
            S_ST2: begin
                cmd.mem_wr_lo = 1'b1;
                state_next    = S_EXEC;
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_TOP;
            end
            S_TOP: state_next = S_FIN;
            S_FIN: begin
                if (!stat.out_busy) begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: design/smx_dp.sv
// Datapath of the stack machine execute block: machine state, stack and
// memory RAMs, fault check, iterative divider and result register.
// Depends on smx_pkg and smx_ram.
`timescale 1ns / 1ps

module smx_dp #(
    parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
    parameter int CALL_DEPTH  = smx_pkg::CALL_DEPTH_DEF,
    parameter int MEM_BYTES   = smx_pkg::MEM_BYTES_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  smx_pkg::cmd_t  cmd,
    output smx_pkg::stat_t stat,
    input  logic [4:0]     action,
    input  logic [15:0]    operand_value,
    input  logic [15:0]    next_pc,
    input  logic           m_tready,
    output logic           m_tvalid,
    output logic [15:0]    pc_out,
    output logic [15:0]    top_value,
    output logic [8:0]     stack_depth,
    output logic           zf_out,
    output logic           halted_out,
    output logic           trap_valid,
    output logic [15:0]    trap_code,
    output logic [2:0]     fault
);
    import smx_pkg::*;

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int DAW = $clog2(STACK_DEPTH);
    localparam int RPW = $clog2(CALL_DEPTH + 1);
    localparam int RAW = $clog2(CALL_DEPTH);
    localparam int MAW = $clog2(MEM_BYTES);

    // request and machine state
    logic [4:0]     op_reg;
    logic [15:0]    opd_reg, pc_reg, pc_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [RPW-1:0] rp_reg, rp_next;
    logic           zf_reg, zf_next, hf_reg, hf_next;
    logic [15:0]    a_reg, b_reg;
    logic [2:0]     fault_reg, fault_next;
    logic           tv_reg, tv_next;
    logic [7:0]     hi_reg;
    // divider
    logic [15:0]    rem_reg, quo_reg, dv_reg;
    logic [3:0]     cnt_reg;
    logic           m_valid_reg;

    // RAM ports
    logic           ds_we, mem_we, rs_we;
    logic [DAW-1:0] ds_waddr, ds_raddr;
    logic [15:0]    ds_wdata, ds_rdata, rs_rdata;
    logic [MAW-1:0] mem_waddr, mem_raddr;
    logic [7:0]     mem_wdata, mem_rdata;
    logic [SPW-1:0] sp_m1, sp_m2, need, base;

    assign need  = SPW'(operands_needed(op_reg));
    assign base  = sp_reg - need;
    assign sp_m1 = sp_reg - SPW'(1);
    assign sp_m2 = sp_reg - SPW'(2);

    // top by default, second entry while fetching b
    assign ds_raddr  = cmd.rd_b ? sp_m2[DAW-1:0] : sp_m1[DAW-1:0];
    // memory addresses wrap by truncation
    assign mem_raddr = cmd.mem_lo ? MAW'(a_reg + 16'd1) : a_reg[MAW-1:0];
    assign mem_we    = cmd.mem_wr_hi | cmd.mem_wr_lo;
    assign mem_waddr = cmd.mem_wr_lo ? MAW'(a_reg + 16'd1) : a_reg[MAW-1:0];
    assign mem_wdata = cmd.mem_wr_lo ? b_reg[7:0] : b_reg[15:8];

    smx_ram #(.WIDTH(16), .DEPTH(STACK_DEPTH)) u_ds (
        .clk(aclk), .we(ds_we), .waddr(ds_waddr), .wdata(ds_wdata),
        .raddr(ds_raddr), .rdata(ds_rdata)
    );

    smx_ram #(.WIDTH(16), .DEPTH(CALL_DEPTH)) u_rs (
        .clk(aclk), .we(rs_we), .waddr(rp_reg[RAW-1:0]), .wdata(pc_reg),
        .raddr(RAW'(rp_reg - RPW'(1))), .rdata(rs_rdata)
    );

    smx_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .clk(aclk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .raddr(mem_raddr), .rdata(mem_rdata)
    );

    // fault check, first match wins; a halted machine reports none
    logic [2:0] fault_c;
    always_comb begin
        fault_c = FLT_NONE;
        if (hf_reg) begin
            fault_c = FLT_NONE;
        end else if (op_reg > OP_RET) begin
            fault_c = FLT_BADOP;
        end else if (sp_reg < need) begin
            fault_c = FLT_UNDER;
        end else if ((op_reg == OP_PUSH || op_reg == OP_DUP) &&
                     sp_reg == SPW'(STACK_DEPTH)) begin
            fault_c = FLT_OVER;
        end else if ((op_reg == OP_DIV || op_reg == OP_MOD) && a_reg == 16'd0) begin
            fault_c = FLT_DIV0;
        end else if ((op_reg == OP_CALL && rp_reg == RPW'(CALL_DEPTH)) ||
                     (op_reg == OP_RET && rp_reg == '0)) begin
            fault_c = FLT_CALL;
        end
    end

    assign stat.skip      = hf_reg | (fault_c != FLT_NONE);
    assign stat.is_divmod = (op_reg == OP_DIV) || (op_reg == OP_MOD);
    assign stat.is_load   = (op_reg == OP_LOAD);
    assign stat.is_store  = (op_reg == OP_STOR);
    assign stat.div_last  = (cnt_reg == 4'd15);
    assign stat.out_busy  = m_valid_reg & ~m_tready;

    // divider step on magnitudes: b / a
    logic [16:0] trial;
    assign trial = {rem_reg, quo_reg[15]} - {1'b0, dv_reg};

    // signed fix-up of quotient and remainder
    logic [15:0] quo_s, rem_s;
    assign quo_s = (a_reg[15] ^ b_reg[15]) ? 16'(-quo_reg) : quo_reg;
    assign rem_s = b_reg[15] ? 16'(-rem_reg) : rem_reg;

    // commit of one instruction
    logic [15:0] r;
    logic        sets_zero;
    logic [31:0] prod;
    assign prod = b_reg * a_reg;

    always_comb begin
        pc_next    = pc_reg;
        sp_next    = sp_reg;
        rp_next    = rp_reg;
        zf_next    = zf_reg;
        hf_next    = hf_reg;
        fault_next = fault_reg;
        tv_next    = tv_reg;
        ds_we      = 1'b0;
        ds_waddr   = base[DAW-1:0];
        ds_wdata   = a_reg;
        rs_we      = 1'b0;
        r          = 16'd0;
        sets_zero  = 1'b0;
        if (cmd.accept) begin
            pc_next = next_pc;
        end
        if (cmd.check) begin
            fault_next = fault_c;
            tv_next    = 1'b0;
        end
        if (cmd.exec) begin
            sp_next = base;
            case (op_reg)
                OP_HALT: hf_next = 1'b1;
                OP_TRAP: tv_next = 1'b1;
                OP_LOAD: begin
                    ds_we    = 1'b1;
                    ds_wdata = {hi_reg, mem_rdata};
                    sp_next  = base + SPW'(1);
                end
                OP_PUSH: begin
                    ds_we    = 1'b1;
                    ds_wdata = opd_reg;
                    sp_next  = base + SPW'(1);
                end
                // entry below already holds a: write the copy above it
                OP_DUP: begin
                    ds_we    = 1'b1;
                    ds_waddr = sp_reg[DAW-1:0];
                    sp_next  = base + SPW'(2);
                end
                OP_ADD: begin r = b_reg + a_reg;  sets_zero = 1'b1; end
                OP_SUB: begin r = b_reg - a_reg;  sets_zero = 1'b1; end
                OP_MUL: begin r = prod[15:0];     sets_zero = 1'b1; end
                OP_DIV: begin r = quo_s;          sets_zero = 1'b1; end
                OP_MOD: begin r = rem_s;          sets_zero = 1'b1; end
                OP_AND: begin r = b_reg & a_reg;  sets_zero = 1'b1; end
                OP_OR:  begin r = b_reg | a_reg;  sets_zero = 1'b1; end
                OP_XOR: begin r = b_reg ^ a_reg;  sets_zero = 1'b1; end
                OP_NOT: begin r = ~a_reg;         sets_zero = 1'b1; end
                OP_LT, OP_GT, OP_EQ: begin
                    ds_we   = 1'b1;
                    sp_next = base + SPW'(1);
                    if (op_reg == OP_LT) begin
                        ds_wdata = {15'd0, $signed(a_reg) < $signed(b_reg)};
                    end else if (op_reg == OP_GT) begin
                        ds_wdata = {15'd0, $signed(a_reg) > $signed(b_reg)};
                    end else begin
                        ds_wdata = {15'd0, a_reg == b_reg};
                    end
                end
                OP_JMP: pc_next = a_reg;
                OP_JZ:  if (zf_reg) pc_next = a_reg;
                OP_JNZ: if (!zf_reg) pc_next = a_reg;
                OP_CALL: begin
                    rs_we   = 1'b1;
                    rp_next = rp_reg + RPW'(1);
                    pc_next = a_reg;
                end
                OP_RET: begin
                    rp_next = rp_reg - RPW'(1);
                    pc_next = rs_rdata;
                end
                default: ;
            endcase
            if (sets_zero) begin
                ds_we    = 1'b1;
                ds_wdata = r;
                sp_next  = base + SPW'(1);
                zf_next  = (r == 16'd0);
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg      <= '0;
            rp_reg      <= '0;
            zf_reg      <= 1'b0;
            hf_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            sp_reg <= sp_next;
            rp_reg <= rp_next;
            zf_reg <= zf_next;
            hf_reg <= hf_next;
            if (cmd.fin) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pc_reg    <= pc_next;
        fault_reg <= fault_next;
        tv_reg    <= tv_next;
        if (cmd.accept) begin
            op_reg  <= action;
            opd_reg <= operand_value;
        end
        if (cmd.cap_a) begin
            a_reg <= ds_rdata;
        end
        if (cmd.check) begin
            b_reg <= ds_rdata;
        end
        if (cmd.mem_lo) begin
            hi_reg <= mem_rdata;
        end
        if (cmd.div_init) begin
            rem_reg <= 16'd0;
            quo_reg <= b_reg[15] ? 16'(-b_reg) : b_reg;
            dv_reg  <= a_reg[15] ? 16'(-a_reg) : a_reg;
            cnt_reg <= 4'd0;
        end else if (cmd.div_step) begin
            rem_reg <= trial[16] ? {rem_reg[14:0], quo_reg[15]} : trial[15:0];
            quo_reg <= {quo_reg[14:0], ~trial[16]};
            cnt_reg <= cnt_reg + 4'd1;
        end
        if (cmd.fin) begin
            pc_out      <= pc_reg;
            top_value   <= (sp_reg == '0) ? 16'd0 : ds_rdata;
            stack_depth <= 9'(sp_reg);
            zf_out      <= zf_reg;
            halted_out  <= hf_reg;
            trap_valid  <= tv_reg;
            trap_code   <= tv_reg ? a_reg : 16'd0;
            fault       <= fault_reg;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

FILE: design/stack_machine_execute_top.sv
// Top level of the stack machine execute block: stream ports, packing,
// sequencer and datapath. Depends on smx_pkg, smx_ctrl and smx_dp.
//
//  Channel  | Ports        | Content
//  ---------+--------------+---------------------------------------------
//  request  | s_t*         | one instruction: opcode, operand, next pc
//  result   | m_t*         | next pc, stack top/depth, flags, trap, fault
//
// Each request walks the sequencer states RDA, RDB, CHK, EXEC, TOP and
// FIN before the result is registered; load adds MEM1 and MEM2, store ST1
// and ST2, and div and mod DIVI and the steps of a 16-step restoring
// divider. A faulted or ignored (halted) request goes from CHK to TOP. One
// request is in flight at a time; a result waiting in the output register
// stalls only the final step of the next one.
// Reset (aresetn low, synchronous) empties both stacks and clears flags;
// stack and data memory contents are not cleared.
`timescale 1ns / 1ps

module stack_machine_execute_top #(
    parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
    parameter int CALL_DEPTH  = smx_pkg::CALL_DEPTH_DEF,
    parameter int MEM_BYTES   = smx_pkg::MEM_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // action[4:0], operand_value[20:5], next_pc[36:21], zero fill
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pc_out[15:0], top_value[31:16], stack_depth[40:32],
    // zf_out[41], halted_out[42], trap_valid[43],
    // trap_code[59:44], fault[62:60], zero fill
    output logic [63:0] m_tdata
);
    import smx_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    logic [15:0] pc_out, top_value, trap_code;
    logic [8:0]  stack_depth;
    logic        zf_out, halted_out, trap_valid;
    logic [2:0]  fault;

    smx_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .stat(stat), .cmd(cmd)
    );

    smx_dp #(
        .STACK_DEPTH(STACK_DEPTH), .CALL_DEPTH(CALL_DEPTH), .MEM_BYTES(MEM_BYTES)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .action(s_tdata[4:0]), .operand_value(s_tdata[20:5]),
        .next_pc(s_tdata[36:21]),
        .m_tready(m_tready), .m_tvalid(m_tvalid),
        .pc_out(pc_out), .top_value(top_value), .stack_depth(stack_depth),
        .zf_out(zf_out), .halted_out(halted_out),
        .trap_valid(trap_valid), .trap_code(trap_code), .fault(fault)
    );

    // result packing, lowest field first
    assign m_tdata = {1'b0, fault, trap_code, trap_valid, halted_out,
                      zf_out, stack_depth, top_value, pc_out};

endmodule

FILE: test/testbench.sv
// Self-checking testbench for stack_machine_execute_top: directed and random
// instruction streams, checked against an in-bench model of the machine.
// Depends on smx_pkg and the design under test.
`timescale 1ns / 1ps

module testbench;
    import smx_pkg::*;

    localparam int SDEPTH   = 256;
    localparam int CDEPTH   = 64;
    localparam int WD_LIMIT = 5000;
    localparam int HOLD_LEN = 400;

    typedef struct packed {
        logic [15:0] pc_out;
        logic [15:0] top_value;
        logic [8:0]  stack_depth;
        logic        zf;
        logic        halted;
        logic        trap_valid;
        logic [15:0] trap_code;
        logic [2:0]  fault;
    } exec_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;

    // machine state as predicted
    logic [15:0] mdl_dstack [SDEPTH];
    logic [15:0] mdl_rstack [CDEPTH];
    logic [7:0]  mdl_mem [65536];
    bit          mdl_written [65536];
    int          mdl_sp = 0;
    int          mdl_rp = 0;
    logic        mdl_zero = 1'b0;
    logic        mdl_halt = 1'b0;

    exec_res_t   pending_q [$];
    logic [15:0] stored_addr [$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_start = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          idle_cycles = 0;

    stack_machine_execute_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // work out one instruction and update the predicted state
    function automatic exec_res_t execute_instr(logic [4:0] op, logic [15:0] opv,
                                                logic [15:0] pc);
        exec_res_t r;
        int need;
        logic [15:0] a, b, v;
        logic [2:0] flt;
        bit sets_zero;
        int sa, sb;
        r = '0;
        flt = FLT_NONE;
        if (!mdl_halt) begin
            need = operands_needed(op);
            a = (mdl_sp >= 1) ? mdl_dstack[mdl_sp-1] : 16'h0;
            b = (mdl_sp >= 2) ? mdl_dstack[mdl_sp-2] : 16'h0;
            sa = $signed(a);
            sb = $signed(b);
            if (op > OP_RET) flt = FLT_BADOP;
            else if (mdl_sp < need) flt = FLT_UNDER;
            else if ((op == OP_PUSH || op == OP_DUP) && mdl_sp >= SDEPTH) flt = FLT_OVER;
            else if ((op == OP_DIV || op == OP_MOD) && a == 16'h0) flt = FLT_DIV0;
            else if ((op == OP_CALL && mdl_rp >= CDEPTH) || (op == OP_RET && mdl_rp == 0))
                flt = FLT_CALL;
            if (flt == FLT_NONE) begin
                sets_zero = 1'b0;
                v = 16'h0;
                mdl_sp -= need;
                case (op)
                    OP_HALT: mdl_halt = 1'b1;
                    OP_TRAP: begin
                        r.trap_valid = 1'b1;
                        r.trap_code = a;
                    end
                    OP_LOAD: mdl_dstack[mdl_sp++] = {mdl_mem[a], mdl_mem[a + 16'd1]};
                    OP_STOR: begin
                        mdl_mem[a] = b[15:8];
                        mdl_mem[a + 16'd1] = b[7:0];
                        mdl_written[a] = 1'b1;
                        mdl_written[a + 16'd1] = 1'b1;
                    end
                    OP_PUSH: mdl_dstack[mdl_sp++] = opv;
                    OP_DUP: begin
                        mdl_dstack[mdl_sp++] = a;
                        mdl_dstack[mdl_sp++] = a;
                    end
                    OP_ADD: begin v = b + a; sets_zero = 1'b1; end
                    OP_SUB: begin v = b - a; sets_zero = 1'b1; end
                    OP_MUL: begin v = b * a; sets_zero = 1'b1; end
                    OP_DIV: begin v = 16'(sb / sa); sets_zero = 1'b1; end
                    OP_MOD: begin v = 16'(sb % sa); sets_zero = 1'b1; end
                    OP_AND: begin v = b & a; sets_zero = 1'b1; end
                    OP_OR:  begin v = b | a; sets_zero = 1'b1; end
                    OP_XOR: begin v = b ^ a; sets_zero = 1'b1; end
                    OP_NOT: begin v = ~a; sets_zero = 1'b1; end
                    OP_LT: mdl_dstack[mdl_sp++] = {15'h0, sa < sb};
                    OP_GT: mdl_dstack[mdl_sp++] = {15'h0, sa > sb};
                    OP_EQ: mdl_dstack[mdl_sp++] = {15'h0, a == b};
                    OP_JMP: pc = a;
                    OP_JZ:  if (mdl_zero) pc = a;
                    OP_JNZ: if (!mdl_zero) pc = a;
                    OP_CALL: begin
                        mdl_rstack[mdl_rp++] = pc;
                        pc = a;
                    end
                    OP_RET: pc = mdl_rstack[--mdl_rp];
                    default: ;
                endcase
                if (sets_zero) begin
                    mdl_dstack[mdl_sp++] = v;
                    mdl_zero = (v == 16'h0);
                end
            end
        end
        r.pc_out = pc;
        r.top_value = (mdl_sp > 0) ? mdl_dstack[mdl_sp-1] : 16'h0;
        r.stack_depth = mdl_sp[8:0];
        r.zf = mdl_zero;
        r.halted = mdl_halt;
        r.fault = flt;
        return r;
    endfunction

    // offer one request and wait for it to be taken
    task automatic send_instr(logic [4:0] op, logic [15:0] opv, logic [15:0] pc);
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b0, pc, opv, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_q.push_back(execute_instr(op, opv, pc));
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge aclk);
        end
    endtask

    task automatic send_op(logic [4:0] op);
        send_instr(op, 16'($urandom), 16'($urandom));
    endtask

    task automatic push_val(logic [15:0] v);
        send_instr(OP_PUSH, v, 16'($urandom));
    endtask

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        errors++;
        $display("%0t: %s mismatch: got %h expected %h", $realtime, what, got, want);
    endtask

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge aclk) begin
        if (hold_start != hold_seen) begin
            hold_seen = hold_start;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker
    always @(posedge aclk) begin
        exec_res_t w, g;
        if (aresetn && m_tvalid && m_tready) begin
            g.pc_out      = m_tdata[15:0];
            g.top_value   = m_tdata[31:16];
            g.stack_depth = m_tdata[40:32];
            g.zf          = m_tdata[41];
            g.halted      = m_tdata[42];
            g.trap_valid  = m_tdata[43];
            g.trap_code   = m_tdata[59:44];
            g.fault       = m_tdata[62:60];
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[15:0], 16'h0);
            end else begin
                w = pending_q.pop_front();
                if (g.pc_out != w.pc_out) report_mismatch("pc_out", g.pc_out, w.pc_out);
                if (g.top_value != w.top_value)
                    report_mismatch("top_value", g.top_value, w.top_value);
                if (g.stack_depth != w.stack_depth)
                    report_mismatch("stack_depth", 16'(g.stack_depth), 16'(w.stack_depth));
                if (g.zf != w.zf)
                    report_mismatch("zero bit", 16'(g.zf), 16'(w.zf));
                if (g.halted != w.halted)
                    report_mismatch("halted", 16'(g.halted), 16'(w.halted));
                if (g.trap_valid != w.trap_valid)
                    report_mismatch("trap_valid", 16'(g.trap_valid), 16'(w.trap_valid));
                if (g.trap_code != w.trap_code)
                    report_mismatch("trap code", g.trap_code, w.trap_code);
                if (g.fault != w.fault) report_mismatch("fault", 16'(g.fault), 16'(w.fault));
                if (m_tdata[63] != 1'b0) report_mismatch("zero fill", 16'(m_tdata[63]), 16'h0);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else if (aresetn) begin
            idle_cycles++;
            if (idle_cycles >= WD_LIMIT) begin
                $display("stack_machine_execute_top regression: fail");
                $finish;
            end
        end
    end

    // stop offering and wait for every outstanding result
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // extremes, each operation but HALT, faults, memory wrap, traps
    task automatic test_directed();
        send_op(OP_ADD);                     // underflow on empty stack
        send_op(OP_RET);                     // call stack empty
        push_val(16'hFFFF);
        push_val(16'h0001);
        send_op(OP_ADD);                     // wraps to zero
        push_val(16'h0000);
        send_op(OP_DIV);                     // divide by zero
        send_op(OP_POP);
        push_val(16'h8000);
        push_val(16'hFFFF);
        send_op(OP_DIV);                     // most negative over minus one
        push_val(16'hFFFF);
        send_op(OP_MOD);
        push_val(16'hFFF9);
        push_val(16'h0002);
        send_op(OP_MOD);                     // truncation toward zero
        push_val(16'h1234);
        send_op(OP_SUB); send_op(OP_DUP); send_op(OP_MUL);
        push_val(16'h00F0); send_op(OP_AND); send_op(OP_NOT);
        push_val(16'h5A5A); send_op(OP_OR); send_op(OP_DUP); send_op(OP_XOR);
        push_val(16'h8000); send_op(OP_LT);
        push_val(16'h7FFF); send_op(OP_GT);
        push_val(16'h0001); send_op(OP_EQ);
        send_instr(5'd25, 16'hFFFF, 16'h0000);
        send_instr(5'd31, 16'h0000, 16'hFFFF);
        send_op(OP_NOP);
        // store across the top of memory, then read it back
        push_val(16'hBEEF); push_val(16'hFFFF); send_op(OP_STOR);
        push_val(16'hFFFF); send_op(OP_LOAD);
        stored_addr.push_back(16'hFFFF);
        push_val(16'hABCD); send_op(OP_JMP);
        push_val(16'h0101); send_op(OP_JZ);
        push_val(16'h0202); send_op(OP_JNZ);
        push_val(16'h4000); send_op(OP_CALL);
        send_op(OP_RET);
        push_val(16'h00A5); send_op(OP_TRAP);
        wait_drain();
    endtask

    // fill the data stack while the receiver holds off, then the call stack
    task automatic test_stack_limits();
        int i;
        send_idle_pct = 0;
        hold_start++;
        while (mdl_sp < SDEPTH) push_val(16'($urandom));
        push_val(16'h1111);                  // overflow
        send_op(OP_DUP);                     // overflow
        send_op(OP_TRAP);
        while (mdl_sp > 0) send_op(OP_POP);
        for (i = 0; i <= CDEPTH; i++) begin
            push_val(16'($urandom));
            send_op(OP_CALL);                // last one faults
        end
        send_op(OP_POP);
        while (mdl_rp > 0) send_op(OP_RET);
        send_op(OP_RET);
        wait_drain();
    endtask

    // mostly well-formed sequences with random content
    task automatic test_random(int n, int sidle, int rstall);
        int k, pick;
        logic [4:0] op;
        logic [15:0] ad;
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        for (k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (mdl_sp < 2 && pick < 60) begin
                push_val((pick < 10) ? 16'h8000 : 16'($urandom));
            end else if (mdl_sp > 200) begin
                send_op(OP_POP);
            end else if (pick < 12) begin
                ad = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(63));
                push_val(16'($urandom));
                push_val(ad);
                send_op(OP_STOR);
                stored_addr.push_back(ad);
            end else if (pick < 20 && stored_addr.size() > 0) begin
                push_val(stored_addr[$urandom_range(stored_addr.size() - 1)]);
                send_op(OP_LOAD);
            end else if (pick < 35) begin
                push_val(($urandom_range(3) == 0) ? 16'h0000 : 16'($urandom));
            end else begin
                op = 5'($urandom_range(31));
                if (op == OP_HALT) op = OP_NOP;
                // never read memory that was not stored
                if (op == OP_LOAD && mdl_sp >= 1 &&
                    !(mdl_written[mdl_dstack[mdl_sp-1]] &&
                      mdl_written[mdl_dstack[mdl_sp-1] + 16'd1]))
                    op = OP_POP;
                send_op(op);
            end
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait_drain();
    endtask

    // once halted everything is ignored
    task automatic test_halt();
        int k;
        send_idle_pct = 10;
        recv_stall_pct = 10;
        push_val(16'h0042);
        send_op(OP_HALT);
        for (k = 0; k < 6; k++) send_instr(5'($urandom), 16'($urandom), 16'($urandom));
        send_op(OP_ADD);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait_drain();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_stack_limits();
        test_random(160, 0, 0);
        test_random(160, 83, 0);
        test_random(160, 0, 83);
        test_random(160, 10, 10);
        test_halt();
        if (errors == 0) begin
            $display("stack_machine_execute_top regression: pass");
        end else begin
            $display("stack_machine_execute_top regression: fail");
        end
        $finish;
    end

endmodule
